[rtl/rrjs_pkg.sv]
// rrjs_pkg: shared types and constants of the round-robin job scheduler
// no dependencies; imported by the interfaces, controller, datapath and top level
`timescale 1ns / 1ps
package rrjs_pkg;

   // parameter defaults
   localparam int MAX_JOBS_DEFAULT  = 16;
   localparam int TIME_BITS_DEFAULT = 16;

   // fixed field widths of the channels
   localparam int SLOT_W  = 4;
   localparam int FIELD_W = 16;
   localparam int SLICE_W = 8;
   localparam int EVENT_W = 3;

   localparam logic [SLICE_W-1:0] SLICE_RESET = 8'd2;
   localparam logic [SLICE_W-1:0] SLICE_MAX   = 8'hFF;

   // per-slot job phase
   typedef enum logic [2:0] {
      PH_EMPTY = 3'd0,
      PH_READY = 3'd1,
      PH_RUN   = 3'd2,
      PH_IO    = 3'd3,
      PH_DONE  = 3'd4
   } phase_type;

   // result event codes
   typedef enum logic [EVENT_W-1:0] {
      EV_ADMIT  = 3'd0,
      EV_REJECT = 3'd1,
      EV_IDLE   = 3'd2,
      EV_RAN    = 3'd3,
      EV_FINISH = 3'd4,
      EV_TOIO   = 3'd5,
      EV_EXPIRE = 3'd6
   } event_type;

   // controller to datapath commands, at most one per cycle
   typedef struct packed {
      logic capture;
      logic arrive;
      logic io_step;
      logic run;
      logic count;
      logic publish;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic req_valid;
      logic req_tick;
      logic io_more;
      logic rsp_busy;
   } status_type;

endpackage

[rtl/rrjs_if.sv]
// rrjs_if: request, response and register-write channel interfaces
// depends on rrjs_pkg for field widths
`timescale 1ns / 1ps
interface rrjs_req_if;
   import rrjs_pkg::*;
   logic                 valid;
   logic                 ready;
   logic                 action;
   logic [SLOT_W-1:0]    arrive_job;
   logic [FIELD_W-1:0]   burst_length;
   logic [FIELD_W-1:0]   io_complete_mask;
   logic                 needs_io;

   modport source (output valid, action, arrive_job, burst_length, io_complete_mask,
                   needs_io, input ready);
   modport sink   (input valid, action, arrive_job, burst_length, io_complete_mask,
                   needs_io, output ready);
endinterface

interface rrjs_rsp_if;
   import rrjs_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [EVENT_W-1:0]   event_res;
   logic [SLOT_W-1:0]    job_slot;
   logic [FIELD_W-1:0]   remaining_after;
   logic [FIELD_W-1:0]   tick_now;
   logic [FIELD_W-1:0]   first_start;
   logic [FIELD_W-1:0]   finish_tick;
   logic [FIELD_W-1:0]   running_ticks;
   logic [FIELD_W-1:0]   ready_ticks;
   logic [FIELD_W-1:0]   waiting_io_ticks;
   logic                 all_done;

   modport source (output valid, event_res, job_slot, remaining_after, tick_now,
                   first_start, finish_tick, running_ticks, ready_ticks,
                   waiting_io_ticks, all_done, input ready);
   modport sink   (input valid, event_res, job_slot, remaining_after, tick_now,
                   first_start, finish_tick, running_ticks, ready_ticks,
                   waiting_io_ticks, all_done, output ready);
endinterface

interface rrjs_csr_if;
   import rrjs_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [SLICE_W-1:0]   data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

[rtl/rrjs_ctrl.sv]
// rrjs_ctrl: sequencing state machine of the scheduler
// depends on rrjs_pkg; drives commands into rrjs_dp and reads its status
`timescale 1ns / 1ps
module rrjs_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  rrjs_pkg::status_type  sts,
   output rrjs_pkg::cmd_type     cmd,
   output logic                  req_ready
);
   import rrjs_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_ARRIVE  = 5'b00010,
      ST_IO      = 5'b00100,
      ST_COUNT   = 5'b01000,
      ST_PUBLISH = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // next state and command decode
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (sts.req_valid) begin
               cmd.capture = 1'b1;
               state_in    = sts.req_tick ? ST_IO : ST_ARRIVE;
            end
         end
         ST_ARRIVE: begin
            cmd.arrive = 1'b1;
            state_in   = ST_PUBLISH;
         end
         ST_IO: begin
            // walk the i/o list, then dispatch and run in the closing cycle
            if (sts.io_more) begin
               cmd.io_step = 1'b1;
            end else begin
               cmd.run  = 1'b1;
               state_in = ST_COUNT;
            end
         end
         ST_COUNT: begin
            cmd.count = 1'b1;
            state_in  = ST_PUBLISH;
         end
         ST_PUBLISH: begin
            if (!sts.rsp_busy) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/rrjs_dp.sv]
// rrjs_dp: job table, ready queue, i/o list and result register
// depends on rrjs_pkg; commanded by rrjs_ctrl
`timescale 1ns / 1ps
module rrjs_dp #(
   parameter int MAX_JOBS  = rrjs_pkg::MAX_JOBS_DEFAULT,
   parameter int TIME_BITS = rrjs_pkg::TIME_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  rrjs_pkg::cmd_type             cmd,
   output rrjs_pkg::status_type          sts,
   // request payload
   input  logic                          req_valid,
   input  logic                          req_action,
   input  logic [rrjs_pkg::SLOT_W-1:0]   req_arrive_job,
   input  logic [rrjs_pkg::FIELD_W-1:0]  req_burst_length,
   input  logic [rrjs_pkg::FIELD_W-1:0]  req_io_complete_mask,
   input  logic                          req_needs_io,
   // register write
   input  logic                          csr_valid,
   input  logic [rrjs_pkg::SLICE_W-1:0]  csr_data,
   // result
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [rrjs_pkg::EVENT_W-1:0]  rsp_event_res,
   output logic [rrjs_pkg::SLOT_W-1:0]   rsp_job_slot,
   output logic [rrjs_pkg::FIELD_W-1:0]  rsp_remaining_after,
   output logic [rrjs_pkg::FIELD_W-1:0]  rsp_tick_now,
   output logic [rrjs_pkg::FIELD_W-1:0]  rsp_first_start,
   output logic [rrjs_pkg::FIELD_W-1:0]  rsp_finish_tick,
   output logic [rrjs_pkg::FIELD_W-1:0]  rsp_running_ticks,
   output logic [rrjs_pkg::FIELD_W-1:0]  rsp_ready_ticks,
   output logic [rrjs_pkg::FIELD_W-1:0]  rsp_waiting_io_ticks,
   output logic                          rsp_all_done
);
   import rrjs_pkg::*;

   localparam int SW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
   localparam int CW = $clog2(MAX_JOBS + 1);
   localparam int TW = TIME_BITS;
   localparam logic [SW-1:0] LAST_SLOT = SW'(MAX_JOBS - 1);

   // per-slot job table
   phase_type         phase_ff [MAX_JOBS];
   logic [TW-1:0]     rem_ff   [MAX_JOBS];
   logic [TW-1:0]     start_ff [MAX_JOBS];
   logic [TW-1:0]     end_ff   [MAX_JOBS];
   logic [TW-1:0]     run_ff   [MAX_JOBS];
   logic [TW-1:0]     rdy_ff   [MAX_JOBS];
   logic [TW-1:0]     iow_ff   [MAX_JOBS];

   // ready queue and i/o list
   logic [SW-1:0]     fifo_ff  [MAX_JOBS];
   logic [SW-1:0]     head_ff, tail_ff;
   logic [CW-1:0]     rcount_ff;
   logic [SW-1:0]     iol_ff   [MAX_JOBS];
   logic [CW-1:0]     iocount_ff, p_ff, kept_ff;

   // scheduler state
   logic              run_valid_ff;
   logic [SW-1:0]     run_slot_ff;
   logic [SLICE_W-1:0] slice_ff;
   logic [SLICE_W-1:0] time_slice_ff;
   logic [TW-1:0]     tick_ff;
   logic [CW-1:0]     adm_ff, fin_ff;

   // captured request and pending event
   logic [SLOT_W-1:0]  arrive_ff;
   logic [FIELD_W-1:0] burst_ff;
   logic [FIELD_W-1:0] mask_ff;
   logic               ioreq_ff;
   logic               is_tick_ff;
   event_type          ev_ff;
   logic [SLOT_W-1:0]  slot_out_ff;
   logic [SW-1:0]      idx_ff;
   logic               has_job_ff;

   // result register
   logic               rsp_valid_ff;
   logic [EVENT_W-1:0] rsp_ev_ff;
   logic [SLOT_W-1:0]  rsp_slot_ff;
   logic [FIELD_W-1:0] rsp_rem_ff, rsp_tick_ff, rsp_start_ff, rsp_end_ff;
   logic [FIELD_W-1:0] rsp_run_ff, rsp_rdy_ff, rsp_iow_ff;
   logic               rsp_done_ff;

   // arrival decode
   logic [SW+3:0]      arr_ext;
   logic               slot_ok, reject;
   logic [SW-1:0]      arr_idx;
   logic [TW+15:0]     burst_ext;

   assign arr_ext   = {{SW{1'b0}}, arrive_ff};
   assign slot_ok   = arr_ext < (SW + 4)'(MAX_JOBS);
   assign arr_idx   = arr_ext[SW-1:0];
   assign reject    = (burst_ff == '0) || !slot_ok || (phase_ff[arr_idx] != PH_EMPTY);
   assign burst_ext = {{TW{1'b0}}, burst_ff};

   // i/o list walk, one position per cycle
   logic [MAX_JOBS+15:0] mask_ext;
   logic [SW-1:0]        io_slot;
   logic                 io_hit;

   assign mask_ext = {{MAX_JOBS{1'b0}}, mask_ff};
   assign io_slot  = iol_ff[p_ff[SW-1:0]];
   assign io_hit   = mask_ext[p_ff];

   // dispatch and one run tick
   logic               disp, have;
   logic [SW-1:0]      run_s;
   logic [TW-1:0]      rem_cur, rem_new, run_new;
   logic [SLICE_W-1:0] slice_inc;
   logic               fin, to_io, expire, leaves;
   logic [SW+3:0]      run_ext;

   assign disp      = !run_valid_ff && (rcount_ff != '0);
   assign have      = run_valid_ff || disp;
   assign run_s     = run_valid_ff ? run_slot_ff : fifo_ff[head_ff];
   assign rem_cur   = rem_ff[run_s];
   assign rem_new   = (rem_cur != '0) ? rem_cur - 1'b1 : rem_cur;
   assign run_new   = (&run_ff[run_s]) ? run_ff[run_s] : run_ff[run_s] + 1'b1;
   assign slice_inc = (slice_ff == SLICE_MAX) ? slice_ff : slice_ff + 1'b1;
   assign fin       = (rem_new == '0);
   assign to_io     = !fin && ioreq_ff;
   assign expire    = !fin && !ioreq_ff && (slice_inc >= time_slice_ff);
   assign leaves    = fin || to_io || expire;
   assign run_ext   = {4'b0, run_s};

   // ready queue push selection
   logic               push_en, pop_en;
   logic [SW-1:0]      push_slot;

   always_comb begin
      push_en   = 1'b0;
      push_slot = arr_idx;
      if (cmd.arrive) begin
         push_en = !reject;
      end else if (cmd.io_step) begin
         push_en   = io_hit;
         push_slot = io_slot;
      end else if (cmd.run) begin
         push_en   = have && expire;
         push_slot = run_s;
      end
   end
   assign pop_en = cmd.run && disp;

   // job phases, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_JOBS; i++) begin
            phase_ff[i] <= PH_EMPTY;
         end
      end else if (cmd.arrive) begin
         if (!reject) begin
            phase_ff[arr_idx] <= PH_READY;
         end
      end else if (cmd.io_step) begin
         if (io_hit) begin
            phase_ff[io_slot] <= PH_READY;
         end
      end else if (cmd.run && have) begin
         if (fin) begin
            phase_ff[run_s] <= PH_DONE;
         end else if (to_io) begin
            phase_ff[run_s] <= PH_IO;
         end else if (expire) begin
            phase_ff[run_s] <= PH_READY;
         end else begin
            phase_ff[run_s] <= PH_RUN;
         end
      end
   end

   // job table payload
   always_ff @(posedge clock) begin
      if (cmd.count) begin
         // wait counters of every queued or i/o-waiting job
         for (int i = 0; i < MAX_JOBS; i++) begin
            if (phase_ff[i] == PH_READY && !(&rdy_ff[i])) begin
               rdy_ff[i] <= rdy_ff[i] + 1'b1;
            end
            if (phase_ff[i] == PH_IO && !(&iow_ff[i])) begin
               iow_ff[i] <= iow_ff[i] + 1'b1;
            end
         end
      end else if (cmd.arrive) begin
         if (!reject) begin
            rem_ff[arr_idx]   <= burst_ext[TW-1:0];
            start_ff[arr_idx] <= '0;
            end_ff[arr_idx]   <= '0;
            run_ff[arr_idx]   <= '0;
            rdy_ff[arr_idx]   <= '0;
            iow_ff[arr_idx]   <= '0;
         end
      end else if (cmd.run && have) begin
         if (disp && run_ff[run_s] == '0) begin
            start_ff[run_s] <= tick_ff;
         end
         rem_ff[run_s] <= rem_new;
         run_ff[run_s] <= run_new;
         if (fin) begin
            end_ff[run_s] <= tick_ff;
         end
      end
   end

   // queue and list storage
   always_ff @(posedge clock) begin
      if (push_en) begin
         fifo_ff[tail_ff] <= push_slot;
      end
      if (cmd.io_step && !io_hit) begin
         iol_ff[kept_ff[SW-1:0]] <= io_slot;
      end else if (cmd.run && have && to_io) begin
         iol_ff[kept_ff[SW-1:0]] <= run_s;
      end
   end

   // scheduler control state
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         tail_ff       <= '0;
         rcount_ff     <= '0;
         iocount_ff    <= '0;
         p_ff          <= '0;
         kept_ff       <= '0;
         run_valid_ff  <= 1'b0;
         run_slot_ff   <= '0;
         slice_ff      <= '0;
         tick_ff       <= '0;
         adm_ff        <= '0;
         fin_ff        <= '0;
         time_slice_ff <= SLICE_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid) begin
            time_slice_ff <= csr_data;
         end
         if (push_en) begin
            tail_ff <= (tail_ff == LAST_SLOT) ? '0 : tail_ff + 1'b1;
         end
         if (pop_en) begin
            head_ff <= (head_ff == LAST_SLOT) ? '0 : head_ff + 1'b1;
         end
         rcount_ff <= rcount_ff + CW'(push_en) - CW'(pop_en);
         if (cmd.capture) begin
            p_ff    <= '0;
            kept_ff <= '0;
         end
         if (cmd.io_step) begin
            p_ff <= p_ff + 1'b1;
            if (!io_hit) begin
               kept_ff <= kept_ff + 1'b1;
            end
         end
         if (cmd.arrive && !reject) begin
            adm_ff <= adm_ff + 1'b1;
         end
         if (cmd.run) begin
            // compacted list length, plus the job leaving for i/o
            iocount_ff <= kept_ff + CW'(have && to_io);
            if (have) begin
               run_slot_ff  <= run_s;
               run_valid_ff <= !leaves;
               slice_ff     <= leaves ? '0 : slice_inc;
               if (fin) begin
                  fin_ff <= fin_ff + 1'b1;
               end
            end
         end
         if (cmd.publish && is_tick_ff && !(&tick_ff)) begin
            tick_ff <= tick_ff + 1'b1;
         end
         if (cmd.publish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // captured request and pending event
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         is_tick_ff <= req_action;
         arrive_ff  <= req_arrive_job;
         burst_ff   <= req_burst_length;
         mask_ff    <= req_io_complete_mask;
         ioreq_ff   <= req_needs_io;
      end
      if (cmd.arrive) begin
         ev_ff       <= reject ? EV_REJECT : EV_ADMIT;
         slot_out_ff <= arrive_ff;
         idx_ff      <= arr_idx;
         has_job_ff  <= !reject;
      end else if (cmd.run) begin
         has_job_ff  <= have;
         idx_ff      <= run_s;
         slot_out_ff <= have ? run_ext[SLOT_W-1:0] : '0;
         if (!have) begin
            ev_ff <= EV_IDLE;
         end else if (fin) begin
            ev_ff <= EV_FINISH;
         end else if (to_io) begin
            ev_ff <= EV_TOIO;
         end else if (expire) begin
            ev_ff <= EV_EXPIRE;
         end else begin
            ev_ff <= EV_RAN;
         end
      end
   end

   // result fields cut or widened to the channel width
   logic [TW+15:0] w_rem, w_tick, w_start, w_end, w_run, w_rdy, w_iow;

   assign w_rem   = {16'b0, rem_ff[idx_ff]};
   assign w_tick  = {16'b0, tick_ff};
   assign w_start = {16'b0, start_ff[idx_ff]};
   assign w_end   = {16'b0, end_ff[idx_ff]};
   assign w_run   = {16'b0, run_ff[idx_ff]};
   assign w_rdy   = {16'b0, rdy_ff[idx_ff]};
   assign w_iow   = {16'b0, iow_ff[idx_ff]};

   // result register load
   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         rsp_ev_ff    <= ev_ff;
         rsp_slot_ff  <= slot_out_ff;
         rsp_tick_ff  <= w_tick[FIELD_W-1:0];
         rsp_done_ff  <= (fin_ff == adm_ff);
         rsp_rem_ff   <= has_job_ff ? w_rem[FIELD_W-1:0]   : '0;
         rsp_start_ff <= has_job_ff ? w_start[FIELD_W-1:0] : '0;
         rsp_end_ff   <= has_job_ff ? w_end[FIELD_W-1:0]   : '0;
         rsp_run_ff   <= has_job_ff ? w_run[FIELD_W-1:0]   : '0;
         rsp_rdy_ff   <= has_job_ff ? w_rdy[FIELD_W-1:0]   : '0;
         rsp_iow_ff   <= has_job_ff ? w_iow[FIELD_W-1:0]   : '0;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_event_res        = rsp_ev_ff;
   assign rsp_job_slot         = rsp_slot_ff;
   assign rsp_remaining_after  = rsp_rem_ff;
   assign rsp_tick_now         = rsp_tick_ff;
   assign rsp_first_start      = rsp_start_ff;
   assign rsp_finish_tick      = rsp_end_ff;
   assign rsp_running_ticks    = rsp_run_ff;
   assign rsp_ready_ticks      = rsp_rdy_ff;
   assign rsp_waiting_io_ticks = rsp_iow_ff;
   assign rsp_all_done         = rsp_done_ff;

   // status to the controller
   assign sts.req_valid = req_valid;
   assign sts.req_tick  = req_action;
   assign sts.io_more   = (p_ff < iocount_ff);
   assign sts.rsp_busy  = rsp_valid_ff && !rsp_ready;

endmodule

[rtl/round_robin_job_scheduler.sv]
// Round-robin job scheduler with a time slice. An arrival item admits a job
// slot with its burst length into a FIFO ready queue; a tick item returns
// finished I/O jobs to the queue, dispatches, runs the current job one tick,
// then finishes it, sends it to I/O or preempts it when the slice runs out,
// and bumps every waiting job's counters. Each item gives exactly one result.
// An arrival passes through the capture, arrive and publish states; a tick
// walks and compacts the I/O wait list one position per cycle, then runs,
// counts and publishes. A result held on the output does not block the next
// item until that item's own result is due. The time-slice register may be
// written at any cycle the block is idle; csr_ch.ready is always high.
// depends on rrjs_pkg, rrjs_if, rrjs_ctrl and rrjs_dp
`timescale 1ns / 1ps
module round_robin_job_scheduler #(
   parameter int MAX_JOBS  = rrjs_pkg::MAX_JOBS_DEFAULT,
   parameter int TIME_BITS = rrjs_pkg::TIME_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   rrjs_req_if.sink    req_ch,
   rrjs_rsp_if.source  rsp_ch,
   rrjs_csr_if.sink    csr_ch
);
   import rrjs_pkg::*;

   cmd_type    cmd;
   status_type sts;
   logic       req_ready;

   // sequencer
   rrjs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .sts       (sts),
      .cmd       (cmd),
      .req_ready (req_ready)
   );

   // job storage and scheduling datapath
   rrjs_dp #(
      .MAX_JOBS  (MAX_JOBS),
      .TIME_BITS (TIME_BITS)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .sts                  (sts),
      .req_valid            (req_ch.valid),
      .req_action           (req_ch.action),
      .req_arrive_job       (req_ch.arrive_job),
      .req_burst_length     (req_ch.burst_length),
      .req_io_complete_mask (req_ch.io_complete_mask),
      .req_needs_io         (req_ch.needs_io),
      .csr_valid            (csr_ch.valid),
      .csr_data             (csr_ch.data),
      .rsp_ready            (rsp_ch.ready),
      .rsp_valid            (rsp_ch.valid),
      .rsp_event_res        (rsp_ch.event_res),
      .rsp_job_slot         (rsp_ch.job_slot),
      .rsp_remaining_after  (rsp_ch.remaining_after),
      .rsp_tick_now         (rsp_ch.tick_now),
      .rsp_first_start      (rsp_ch.first_start),
      .rsp_finish_tick      (rsp_ch.finish_tick),
      .rsp_running_ticks    (rsp_ch.running_ticks),
      .rsp_ready_ticks      (rsp_ch.ready_ticks),
      .rsp_waiting_io_ticks (rsp_ch.waiting_io_ticks),
      .rsp_all_done         (rsp_ch.all_done)
   );

   assign req_ch.ready = req_ready;
   assign csr_ch.ready = 1'b1;

`ifndef SYNTHESIS
   // the controller issues at most one command per cycle
   assert property (@(posedge clock) disable iff (reset) $onehot0(cmd))
      else $error("more than one datapath command in a cycle");

   // an accepted request closes the request side on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> !req_ch.ready)
      else $error("request accepted while an item is in progress");

   // a result is only loaded when the output register is free
   assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> !(rsp_ch.valid && !rsp_ch.ready))
      else $error("result overwritten before its transfer");
`endif

endmodule

[test/tb_round_robin_job_scheduler.sv]
// testbench of the round-robin job scheduler: directed and random arrivals and ticks,
// results checked in order against a scheduler model kept in the bench
// depends on rrjs_pkg, rrjs_if and the round_robin_job_scheduler rtl
`timescale 1ns / 1ps
module tb_round_robin_job_scheduler;
   import rrjs_pkg::*;

   localparam int NJ = 16;
   localparam logic [15:0] TOP = 16'hFFFF;
   localparam logic ACT_ARRIVE = 1'b0;
   localparam logic ACT_TICK   = 1'b1;
   localparam int CYCLE_LIMIT = 1500000;

   typedef struct packed {
      event_type   ev;
      logic [3:0]  slot;
      logic [15:0] remaining;
      logic [15:0] tick;
      logic [15:0] start;
      logic [15:0] fin;
      logic [15:0] run_n;
      logic [15:0] ready_n;
      logic [15:0] io_n;
      logic        done;
   } outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rrjs_req_if req_ch ();
   rrjs_rsp_if rsp_ch ();
   rrjs_csr_if csr_ch ();

   round_robin_job_scheduler uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source),
      .csr_ch (csr_ch.sink)
   );

   // clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // scheduler model state
   logic [7:0]  slice_len;
   phase_type   phase [NJ];
   logic [15:0] remain [NJ], t_start [NJ], t_end [NJ];
   logic [15:0] n_run [NJ], n_ready [NJ], n_io [NJ];
   logic [3:0]  rq [NJ];
   int          rq_head, rq_count;
   logic [3:0]  io_list [NJ];
   int          io_count;
   logic [3:0]  cur_slot;
   logic        cur_valid;
   int          slice_used;
   logic [15:0] clk_now;
   int          n_admitted, n_finished;

   outcome_type expected_q[$];
   int errors = 0;
   int cycles = 0;
   bit hold_off = 0;

   function automatic logic [15:0] bump(logic [15:0] v);
      return (v == TOP) ? v : v + 16'd1;
   endfunction

   function automatic void model_reset();
      slice_len = SLICE_RESET;
      foreach (phase[i]) begin
         phase[i] = PH_EMPTY;
         remain[i] = 0; t_start[i] = 0; t_end[i] = 0;
         n_run[i] = 0; n_ready[i] = 0; n_io[i] = 0;
         rq[i] = 0; io_list[i] = 0;
      end
      rq_head = 0; rq_count = 0; io_count = 0;
      cur_slot = 0; cur_valid = 0; slice_used = 0;
      clk_now = 0; n_admitted = 0; n_finished = 0;
   endfunction

   function automatic void enqueue_ready(logic [3:0] s);
      if (rq_count < NJ) begin
         rq[(rq_head + rq_count) % NJ] = s;
         rq_count++;
         phase[s] = PH_READY;
      end
   endfunction

   function automatic outcome_type make_outcome(event_type ev, logic [3:0] s, bit with_job);
      outcome_type o;
      o = '0;
      o.ev = ev;
      o.slot = s;
      o.tick = clk_now;
      o.done = (n_finished == n_admitted);
      if (with_job) begin
         o.remaining = remain[s]; o.start = t_start[s]; o.fin = t_end[s];
         o.run_n = n_run[s]; o.ready_n = n_ready[s]; o.io_n = n_io[s];
      end
      return o;
   endfunction

   // one step of the scheduler: returns the result of the item
   function automatic outcome_type schedule_step(logic act, logic [3:0] job,
         logic [15:0] burst, logic [15:0] mask, logic ioreq);
      logic [3:0] keep [NJ];
      int kept;
      event_type ev;
      logic [3:0] s;
      bit have;
      outcome_type o;
      kept = 0; ev = EV_IDLE; s = 0; have = 0;
      if (act == ACT_ARRIVE) begin
         if (burst == 0 || phase[job] != PH_EMPTY)
            return make_outcome(EV_REJECT, job, 0);
         remain[job] = burst;
         t_start[job] = 0; t_end[job] = 0;
         n_run[job] = 0; n_ready[job] = 0; n_io[job] = 0;
         enqueue_ready(job);
         n_admitted++;
         return make_outcome(EV_ADMIT, job, 1);
      end
      // finished i/o back to the ready queue, list compacted
      for (int p = 0; p < io_count; p++) begin
         if (mask[p]) enqueue_ready(io_list[p]);
         else keep[kept++] = io_list[p];
      end
      for (int p = 0; p < kept; p++) io_list[p] = keep[p];
      io_count = kept;
      // dispatch
      if (!cur_valid && rq_count > 0) begin
         s = rq[rq_head];
         rq_head = (rq_head + 1) % NJ;
         rq_count--;
         if (n_run[s] == 0) t_start[s] = clk_now;
         phase[s] = PH_RUN;
         cur_slot = s; cur_valid = 1; slice_used = 0;
      end
      // run one tick
      if (cur_valid) begin
         s = cur_slot; have = 1;
         if (remain[s] > 0) remain[s]--;
         n_run[s] = bump(n_run[s]);
         if (slice_used < 255) slice_used++;
         if (remain[s] == 0) begin
            phase[s] = PH_DONE; t_end[s] = clk_now; n_finished++;
            cur_valid = 0; slice_used = 0; ev = EV_FINISH;
         end else if (ioreq) begin
            if (io_count < NJ) io_list[io_count++] = s;
            phase[s] = PH_IO; cur_valid = 0; slice_used = 0; ev = EV_TOIO;
         end else if (slice_used >= slice_len) begin
            enqueue_ready(s); cur_valid = 0; slice_used = 0; ev = EV_EXPIRE;
         end else begin
            ev = EV_RAN;
         end
      end
      // waiting counters
      for (int i = 0; i < rq_count; i++)
         n_ready[rq[(rq_head + i) % NJ]] = bump(n_ready[rq[(rq_head + i) % NJ]]);
      for (int i = 0; i < io_count; i++)
         n_io[io_list[i]] = bump(n_io[io_list[i]]);
      o = make_outcome(ev, s, have);
      clk_now = bump(clk_now);
      return o;
   endfunction

   task automatic report(string what, logic [15:0] got, logic [15:0] want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // sender: one transfer on the request channel
   task automatic send_item(logic act, logic [3:0] job, logic [15:0] burst,
         logic [15:0] mask, logic ioreq);
      int gap;
      gap = $urandom_range(0, 7);
      if ($urandom_range(0, 3) == 0) gap = 0;
      // valid stays up from the last transfer only when the next item follows at once
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.action <= act;
      req_ch.arrive_job <= job;
      req_ch.burst_length <= burst;
      req_ch.io_complete_mask <= mask;
      req_ch.needs_io <= ioreq;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      expected_q.push_back(schedule_step(act, job, burst, mask, ioreq));
   endtask

   task automatic arrive(logic [3:0] job, logic [15:0] burst);
      send_item(ACT_ARRIVE, job, burst, 16'($urandom), 1'($urandom));
   endtask

   task automatic tick(logic [15:0] mask, logic ioreq);
      send_item(ACT_TICK, 4'($urandom), 16'($urandom), mask, ioreq);
   endtask

   // wait until idle; a few extra cycles since every item gives a result
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_slice(logic [7:0] v);
      csr_ch.valid <= 1'b1;
      csr_ch.data <= v;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      slice_len = v;
   endtask

   // receiver: random stall per result, checks in order
   initial begin
      int stall;
      outcome_type w;
      rsp_ch.ready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         stall = $urandom_range(0, 7);
         if ($urandom_range(0, 3) == 0) stall = 0;
         while (hold_off) @(posedge clock);
         repeat (stall) @(posedge clock);
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         rsp_ch.ready <= 1'b0;
         if (expected_q.size() == 0) begin
            $display("unexpected result transfer at %0t", $realtime);
            errors++;
         end else begin
            w = expected_q.pop_front();
            if (rsp_ch.event_res !== w.ev)
               report("event_res", 16'(rsp_ch.event_res), 16'(w.ev));
            if (rsp_ch.job_slot !== w.slot)
               report("job_slot", 16'(rsp_ch.job_slot), 16'(w.slot));
            if (rsp_ch.remaining_after !== w.remaining)
               report("remaining_after", rsp_ch.remaining_after, w.remaining);
            if (rsp_ch.tick_now !== w.tick) report("tick_now", rsp_ch.tick_now, w.tick);
            if (rsp_ch.first_start !== w.start)
               report("first_start", rsp_ch.first_start, w.start);
            if (rsp_ch.finish_tick !== w.fin)
               report("finish_tick", rsp_ch.finish_tick, w.fin);
            if (rsp_ch.running_ticks !== w.run_n)
               report("running_ticks", rsp_ch.running_ticks, w.run_n);
            if (rsp_ch.ready_ticks !== w.ready_n)
               report("ready_ticks", rsp_ch.ready_ticks, w.ready_n);
            if (rsp_ch.waiting_io_ticks !== w.io_n)
               report("waiting_io_ticks", rsp_ch.waiting_io_ticks, w.io_n);
            if (rsp_ch.all_done !== w.done)
               report("all_done", 16'(rsp_ch.all_done), 16'(w.done));
         end
      end
   end

   // cycle limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[round_robin_job_scheduler] ERROR");
         $finish;
      end
   end

   // restart the job table by reset of the model is not allowed, so slots are
   // filled once; a fresh job set needs all slots free, which happens only once

   task automatic test_directed();
      // idle tick, rejections, admissions at the extremes
      tick(16'h0000, 1'b1);
      arrive(4'd0, 16'd0);
      arrive(4'd0, 16'd1);
      arrive(4'd0, 16'd5);
      arrive(4'd15, 16'hFFFF);
      arrive(4'd1, 16'd3);
      arrive(4'd2, 16'd4);
      // finish, expire, to i/o, i/o return by full mask
      tick(16'h0000, 1'b0);
      tick(16'h0000, 1'b0);
      tick(16'h0000, 1'b1);
      tick(16'hFFFF, 1'b0);
      tick(16'h0000, 1'b1);
      tick(16'h0000, 1'b1);
      tick(16'h0002, 1'b0);
      tick(16'hFFFF, 1'b0);
      repeat (6) tick(16'h0000, 1'b0);
      drain();
   endtask

   // slots remaining after the directed part, plus long job 15 kept running
   task automatic test_random_schedule(int n_items);
      for (int k = 0; k < n_items; k++) begin
         int r;
         r = $urandom_range(0, 9);
         if (r == 0)
            arrive(4'($urandom), ($urandom_range(0, 5) == 0) ? 16'($urandom)
                                                            : 16'($urandom_range(0, 12)));
         else
            tick(16'(($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 3)),
                 $urandom_range(0, 3) == 0);
         if (k % 200 == 199) begin
            drain();
            case ($urandom_range(0, 3))
               0: write_slice(8'd1);
               1: write_slice(8'd255);
               2: write_slice(8'd0);
               default: write_slice(8'($urandom));
            endcase
         end
      end
      drain();
   endtask

   // receiver holds off while the sender keeps offering ticks
   task automatic test_backpressure();
      hold_off = 1;
      fork
         begin
            repeat (300) @(posedge clock);
            hold_off = 0;
         end
         repeat (40) tick(16'($urandom), 1'($urandom));
      join
      drain();
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.action = ACT_TICK;
      req_ch.arrive_job = '0;
      req_ch.burst_length = '0;
      req_ch.io_complete_mask = '0;
      req_ch.needs_io = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.data = '0;
      model_reset();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      write_slice(8'd1);
      test_random_schedule(600);
      test_backpressure();
      write_slice(8'd3);
      test_random_schedule(500);
      drain();
      if (errors == 0)
         $display("[round_robin_job_scheduler] OK");
      else
         $display("[round_robin_job_scheduler] ERROR");
      $finish;
   end
endmodule

[filelist.f]
rtl/rrjs_pkg.sv
rtl/rrjs_if.sv
rtl/rrjs_ctrl.sv
rtl/rrjs_dp.sv
rtl/round_robin_job_scheduler.sv
test/tb_round_robin_job_scheduler.sv
